/* rtl/cfm_pkg.sv */
// Package for complex_field_moments: types, constants and helpers.
`default_nettype none
package cfm_pkg;

  localparam int MAX_LOG2_COUNT = 16;
  localparam int KW = $clog2(MAX_LOG2_COUNT + 1);

  localparam logic [4:0] RST_LOG2_COUNT = 5'd16;
  localparam logic [31:0] RST_AREA_SCALE = 32'd65536;

  localparam logic [0:0] REG_LOG2_COUNT = 1'b0;
  localparam logic [0:0] REG_AREA_SCALE = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        peak_mag;
    logic [15:0]        mean_mag;
    logic signed [15:0] mean_re;
    logic signed [15:0] mean_im;
    logic [31:0]        condensate;
    logic [47:0]        norm;
    logic [62:0]        potential_energy;
  } out_word_t;

endpackage
`default_nettype wire

/* rtl/cfm_isqrt.sv */
// Iterative integer square root of a 32-bit value, one result bit per cycle.
`default_nettype none
module cfm_isqrt import cfm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] x,
  output logic             busy,
  output logic             done,
  output logic [15:0]      root
);
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = x;
      res_nxt  = '0;
      bit_nxt  = 32'h4000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= res_r + bit_r) begin
        rem_nxt = rem_r - (res_r + bit_r);
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 32'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = res_r[15:0];
endmodule
`default_nettype wire

/* rtl/cfm_front.sv */
// Front end: takes samples into a short queue.
`default_nettype none
module cfm_front import cfm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output logic          q_valid,
  input  wire logic     q_pop,
  output in_word_t      q_data
);
  localparam int DEPTH = 2;
  in_word_t    mem_r [DEPTH];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;

  assign in_ready = (cnt_r != 2'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/cfm_back.sv */
// Back end: accumulates moments and forms the field result.
`default_nettype none
module cfm_back import cfm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire in_word_t    q_data,
  input  wire logic [4:0]  log2_count,
  input  wire logic [31:0] area_scale,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_ROOT = 4'd2, S_QUAD = 4'd3,
                         S_ACC = 4'd4, S_PK = 4'd5, S_MEAN = 4'd6, S_CND = 4'd7,
                         S_NA = 4'd8, S_NB = 4'd9, S_PA = 4'd10, S_PB = 4'd11,
                         S_FIN = 4'd12;
  logic [3:0] st_r;

  logic signed [15:0] re_r, im_r;
  logic               last_r;
  logic [31:0]        sq_r, p1_r, p2_r;
  logic [47:0]        quad_r;
  logic [15:0]        mag_r;
  logic [32:0]        sum_re_r, sum_im_r;
  logic [31:0]        sum_mag_r, peak_sq_r;
  logic [47:0]        sum_sq_r;
  logic [61:0]        sum_quad_r;
  logic [63:0]        hi_r, lo_r;
  logic [KW-1:0]      k_r;
  out_word_t          res_r;
  logic               ov_r;

  logic        sq_start, sq_busy, sq_done;
  logic [31:0] sq_x;
  logic [31:0] sq_c;
  logic [15:0] sq_root;

  cfm_isqrt u_isqrt (.clk, .rst_n, .start(sq_start), .x(sq_x),
                     .busy(sq_busy), .done(sq_done), .root(sq_root));

  // squared magnitude of the held sample, fed straight to the root unit
  assign sq_c     = 32'($signed(32'(re_r)) * re_r) + 32'($signed(32'(im_r)) * im_r);
  // peak root waits until the previous result has been taken
  assign sq_start = (st_r == S_SQ) || ((st_r == S_PK) && !ov_r);
  assign sq_x     = (st_r == S_PK) ? peak_sq_r : sq_c;
  assign q_pop    = (st_r == S_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  // floor(sum / 2^k) saturated to 16 bits
  function automatic logic [15:0] mean_c(input logic [32:0] s, input logic [KW-1:0] k);
    logic signed [32:0] q;
    q = $signed(s) >>> k;
    if (q > 33'sd32767) mean_c = 16'h7fff;
    else if (q < -33'sd32768) mean_c = 16'h8000;
    else mean_c = q[15:0];
  endfunction

  logic [61:0] a_sh;
  logic [29:0] a_hi;
  logic [31:0] a_lo;
  always_comb begin
    a_sh = (st_r == S_NA) ? 62'(sum_sq_r >> k_r) : (sum_quad_r >> k_r);
    a_hi = a_sh[61:32];
    a_lo = a_sh[31:0];
  end

  logic [63:0] nr;
  logic [64:0] pr;
  always_comb begin
    nr = (hi_r << 16) + (lo_r >> 16);
    pr = ({1'b0, hi_r} << 15) + 65'(lo_r >> 17);
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        re_r <= q_data.sample_re;
        im_r <= q_data.sample_im;
        last_r <= q_data.last_sample;
      end
      S_SQ: sq_r <= sq_c;
      S_ROOT: if (sq_done) mag_r <= sq_root;
      S_QUAD: quad_r <= 48'((64'(sq_r) * 64'(sq_r)) >> 16);
      S_ACC: begin
        sum_re_r   <= sum_re_r + 33'(re_r);
        sum_im_r   <= sum_im_r + 33'(im_r);
        sum_mag_r  <= sum_mag_r + 32'(mag_r);
        sum_sq_r   <= sum_sq_r + 48'(sq_r);
        sum_quad_r <= sum_quad_r + 62'(quad_r);
        if (sq_r > peak_sq_r) peak_sq_r <= sq_r;
        k_r <= (log2_count > 5'(MAX_LOG2_COUNT)) ? KW'(MAX_LOG2_COUNT) : KW'(log2_count);
      end
      S_PK: ;
      S_MEAN: if (sq_done) begin
        res_r.peak_mag <= sq_root;
        res_r.mean_mag <= ((sum_mag_r >> k_r) > 32'd65535) ? 16'hffff
                          : 16'(sum_mag_r >> k_r);
        res_r.mean_re <= mean_c(sum_re_r, k_r);
        res_r.mean_im <= mean_c(sum_im_r, k_r);
      end
      S_CND: begin
        p1_r <= 32'(res_r.mean_re * res_r.mean_re);
        p2_r <= 32'(res_r.mean_im * res_r.mean_im);
      end
      S_NA, S_PA: begin
        res_r.condensate <= p1_r + p2_r;
        hi_r <= 64'(a_hi) * 64'(area_scale);
        lo_r <= 64'(a_lo) * 64'(area_scale);
      end
      S_NB: res_r.norm <= (hi_r >= 64'(1) << 32 || nr[63:48] != '0) ? '1 : nr[47:0];
      S_PB: res_r.potential_energy <=
              (hi_r >= 64'(1) << 48 || pr[64:63] != '0) ? '1 : pr[62:0];
      default: ;
    endcase
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
      sum_re_r <= '0; sum_im_r <= '0; sum_mag_r <= '0;
      sum_sq_r <= '0; sum_quad_r <= '0; peak_sq_r <= '0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) st_r <= S_SQ;
        S_SQ:   st_r <= S_ROOT;
        S_ROOT: if (sq_done) st_r <= S_QUAD;
        S_QUAD: st_r <= S_ACC;
        S_ACC:  st_r <= last_r ? S_PK : S_IDLE;
        S_PK:   if (!ov_r) st_r <= S_MEAN;
        S_MEAN: if (sq_done) st_r <= S_CND;
        S_CND:  st_r <= S_NA;
        S_NA:   st_r <= S_NB;
        S_NB:   st_r <= S_PA;
        S_PA:   st_r <= S_PB;
        S_PB:   st_r <= S_FIN;
        S_FIN: if (!ov_r) begin
          ov_r <= 1'b1; st_r <= S_IDLE;
          sum_re_r <= '0; sum_im_r <= '0; sum_mag_r <= '0;
          sum_sq_r <= '0; sum_quad_r <= '0; peak_sq_r <= '0;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_IDLE) else $error("pop outside idle");
  a_ov_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_od_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed while held");
  a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_busy) else $error("sqrt restarted while busy");
endmodule
`default_nettype wire

/* rtl/complex_field_moments.sv */
// Top level of complex_field_moments: config registers, front queue, back end.
// Usage:
//  - in_ channel carries one sample word (re, im, last flag), valid/ready.
//  - out_ channel carries one result word per field, after the sample
//    flagged last; valid/ready, held until taken.
//  - cfg_ port writes log2_count (index 0) or area_scale (index 1) when
//    cfg_we is high; other indexes are ignored. Write only while idle.
// Flow:
//  - each sample passes through the back end in order: take, square,
//    the bit-per-cycle square root unit, the quartic term, accumulate;
//    the back end takes the next sample only when back in idle.
//  - after the last sample, before out_valid: a second root pass on the
//    peak and two split 62x32 multiplies for norm and energy.
//  - a two-word queue lets the front accept while the back end works.
// Reset (synchronous, rst_n low): sums, peak, queue and handshakes clear,
// registers return to log2_count=16, area_scale=1.0.
// Stall: if out_ready stays low the result holds; the back end waits when
// the next last sample arrives and the queue fills, then in_ready drops.
`default_nettype none
module complex_field_moments import cfm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [4:0]  log2_count_r;
  logic [31:0] area_scale_r;
  logic        q_valid, q_pop;
  in_word_t    q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_count_r <= RST_LOG2_COUNT;
      area_scale_r <= RST_AREA_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOG2_COUNT: log2_count_r <= cfg_data[4:0];
        REG_AREA_SCALE: area_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cfm_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_data,
                     .q_valid, .q_pop, .q_data);

  cfm_back u_back (.clk, .rst_n, .q_valid, .q_pop, .q_data,
                   .log2_count(log2_count_r), .area_scale(area_scale_r),
                   .out_valid, .out_ready, .out_data);
endmodule
`default_nettype wire

/* test/tb_top.sv */
// Testbench for complex_field_moments: random sample stream checked against a field-moment scoreboard.
`default_nettype none

class moments_board;
  // running state of the predictor
  logic [4:0]  log2_count;
  logic [31:0] area_scale;
  logic [32:0] acc_re, acc_im;
  logic [31:0] acc_mag;
  logic [47:0] acc_sq;
  logic [61:0] acc_quad;
  logic [31:0] top_sq;
  cfm_pkg::out_word_t pending[$];
  int errors;

  function new();
    log2_count = 5'd16; area_scale = 32'd65536;
    errors = 0;
    clear();
  endfunction

  function void clear();
    acc_re = '0; acc_im = '0; acc_mag = '0; acc_sq = '0; acc_quad = '0; top_sq = '0;
  endfunction

  function logic [15:0] root32(logic [31:0] x);
    logic [31:0] r, b;
    r = 0; b = 32'h4000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[15:0];
  endfunction

  // floor division of a 33-bit sum by 2^k, clamped to 16 bits
  function logic signed [15:0] comp_mean(logic [32:0] s, int k);
    longint v;
    v = longint'($signed(s)) >>> k;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function logic [62:0] scale_sat(logic [61:0] a, int s, int maxbits);
    logic [95:0] p;
    logic [95:0] lim;
    p = ({34'd0, a} * {64'd0, area_scale}) >> s;
    lim = (96'd1 << maxbits) - 1;
    return (p > lim) ? lim[62:0] : p[62:0];
  endfunction

  function void note_word(cfm_pkg::in_word_t w);
    logic [31:0] sq;
    logic [63:0] q;
    logic [15:0] m;
    int k;
    longint mm;
    cfm_pkg::out_word_t o;
    sq = 32'($signed(w.sample_re) * $signed(w.sample_re))
       + 32'($signed(w.sample_im) * $signed(w.sample_im));
    m = root32(sq);
    q = {32'd0, sq} * {32'd0, sq};
    acc_re += {{17{w.sample_re[15]}}, w.sample_re};
    acc_im += {{17{w.sample_im[15]}}, w.sample_im};
    acc_mag += m;
    acc_sq += sq;
    acc_quad += q[63:16];
    if (sq > top_sq) top_sq = sq;
    if (!w.last_sample) return;
    k = (log2_count > 16) ? 16 : log2_count;
    o.peak_mag = root32(top_sq);
    mm = acc_mag >> k;
    o.mean_mag = (mm > 65535) ? 16'hFFFF : mm[15:0];
    o.mean_re = comp_mean(acc_re, k);
    o.mean_im = comp_mean(acc_im, k);
    o.condensate = 32'(o.mean_re * o.mean_re) + 32'(o.mean_im * o.mean_im);
    o.norm = 48'(scale_sat({14'd0, acc_sq >> k}, 16, 48));
    o.potential_energy = scale_sat(acc_quad >> k, 17, 63);
    pending.push_back(o);
    clear();
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  task check_word(cfm_pkg::out_word_t g);
    cfm_pkg::out_word_t e;
    if (pending.size() == 0) begin
      report("unexpected word", g.norm, 0);
      return;
    end
    e = pending.pop_front();
    if (g.peak_mag !== e.peak_mag) report("peak_mag", g.peak_mag, e.peak_mag);
    if (g.mean_mag !== e.mean_mag) report("mean_mag", g.mean_mag, e.mean_mag);
    if (g.mean_re !== e.mean_re) report("mean_re", g.mean_re, e.mean_re);
    if (g.mean_im !== e.mean_im) report("mean_im", g.mean_im, e.mean_im);
    if (g.condensate !== e.condensate) report("condensate", g.condensate, e.condensate);
    if (g.norm !== e.norm) report("norm", g.norm, e.norm);
    if (g.potential_energy !== e.potential_energy)
      report("potential_energy", g.potential_energy, e.potential_energy);
  endtask
endclass

module tb_top;
  import cfm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 2000000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_word_t in_data;
  out_word_t out_data;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  moments_board board;
  longint cycles;
  bit calm;   // when set, neither side idles

  complex_field_moments dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // cycle limit guard
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: random stall on ready, check each accepted word at the rising edge
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_word(out_data);
      @(negedge clk);
      out_ready = calm || ($urandom_range(99) >= 38);
    end
  end

  task write_reg(logic [0:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    if (idx == REG_LOG2_COUNT) board.log2_count = val[4:0];
    else board.area_scale = val;
  endtask

  // drive one word; valid is held until accepted
  task send_word(logic [15:0] re, logic [15:0] im, logic last);
    if (!calm) while ($urandom_range(99) < 38) @(negedge clk);
    in_valid = 1;
    in_data.sample_re = re; in_data.sample_im = im; in_data.last_sample = last;
    do @(posedge clk); while (!in_ready);
    board.note_word(in_data);
    @(negedge clk);
    in_valid = 0;
  endtask

  // wait for every expected word, then let the back end settle
  task drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function logic [15:0] rnd_comp();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task send_field(int n);
    for (int i = 0; i < n; i++) send_word(rnd_comp(), rnd_comp(), i == n - 1);
  endtask

  int sent;
  int lg;

  initial begin
    board = new();
    rst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    calm = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes with reset config, single-sample fields and one of two samples
    send_word(16'h8000, 16'h8000, 1);
    send_word(16'h7FFF, 16'h7FFF, 1);
    send_word(16'h0000, 16'h0000, 1);
    send_word(16'hFFFF, 16'h0001, 0);
    send_word(16'h8000, 16'h7FFF, 1);
    drain();
    // peak tie: equal squares do not replace the peak
    write_reg(REG_LOG2_COUNT, 5'd0);
    write_reg(REG_AREA_SCALE, 32'hFFFF_FFFF);
    send_word(16'h8000, 16'h8000, 1);   // largest scale; norm and energy stay below saturation
    send_word(16'h0003, 16'h0004, 0);
    send_word(16'h0004, 16'h0003, 0);
    send_word(16'hFFFF, 16'hFFFF, 1);   // ends the tie field; with log2_count 0 the mean is the sum
    send_word(16'h7FFF, 16'h7FFF, 0);
    send_word(16'h7FFF, 16'h7FFF, 1);   // mean clamps to 32767
    send_word(16'h8000, 16'h8000, 0);
    send_word(16'h8000, 16'h8000, 1);   // mean clamps to -32768
    drain();
    write_reg(REG_LOG2_COUNT, 5'd31);   // above the cap, acts as 16
    write_reg(REG_AREA_SCALE, 32'd0);
    send_word(16'h1234, 16'hEDCB, 0);
    send_word(16'h8000, 16'h0000, 1);
    drain();

    // random phases through several settings; the first runs without idling
    sent = 0;
    while (sent < 1430) begin
      lg = $urandom_range(5);
      write_reg(REG_LOG2_COUNT, ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'(lg));
      case ($urandom_range(3))
        0: write_reg(REG_AREA_SCALE, 32'hFFFF_FFFF);
        1: write_reg(REG_AREA_SCALE, 32'd65536);
        default: write_reg(REG_AREA_SCALE, $urandom);
      endcase
      calm = (sent == 0) || ($urandom_range(5) == 0);
      for (int f = 0; f < 8; f++) begin
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : (1 << lg);
        send_field(n);
        sent += n;
      end
      drain();   // sender holds off until all results are in
    end
    calm = 0;
    drain();
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
rtl/cfm_pkg.sv
rtl/cfm_isqrt.sv
rtl/cfm_front.sv
rtl/cfm_back.sv
rtl/complex_field_moments.sv
test/tb_top.sv
